>>> hw/rtl/hrhp_pkg.sv
// ---------------------------------------------------------------------------
// HTTP request head parser package
// Shared event codes, result bundle, character constants and match tables.
// ---------------------------------------------------------------------------
package hrhp_pkg;

    localparam int OUT_WIDTH = 32;

    typedef enum logic [2:0] {
        EV_GET = 3'd0,
        EV_PUT = 3'd1,
        EV_BAD = 3'd2,
        EV_LEN = 3'd3,
        EV_END = 3'd4
    } t_event;

    typedef struct packed {
        logic                 valid;
        t_event               evt;
        logic [OUT_WIDTH-1:0] length_val;
    } t_result;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] VERB_CHARS = 4'd3;
    localparam logic [3:0] NAME_LEN   = 4'd14;
    localparam logic [3:0] SEG_MAX    = 4'd15;

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h47; // G
            2'd1:    c = 8'h45; // E
            default: c = 8'h54; // T
        endcase
        return c;
    endfunction

    function automatic logic [7:0] put_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h50; // P
            2'd1:    c = 8'h55; // U
            default: c = 8'h54; // T
        endcase
        return c;
    endfunction

    // "Content-Length"
    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6e;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2d;
            4'd8:    c = 8'h4c;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6e;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/hrhp_core.sv
// ---------------------------------------------------------------------------
// HTTP request head parser core
// Parser state and the combinational byte step that produces at most one event.
// ---------------------------------------------------------------------------
module hrhp_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_new,
    output hrhp_pkg::t_result o_res
);
    import hrhp_pkg::*;

    localparam int ExtW  = (VALUE_WIDTH > OUT_WIDTH) ? VALUE_WIDTH : OUT_WIDTH;
    localparam int ProdW = VALUE_WIDTH + 4;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_HEADERS = 3'd1,
        PH_SEARCH  = 3'd2,
        PH_INVALID = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    t_phase                 r_phase,  n_phase,  e_phase;
    logic [3:0]             r_seg,    n_seg,    e_seg;
    logic                   r_get,    n_get,    e_get;
    logic                   r_put,    n_put,    e_put;
    logic                   r_name,   n_name,   e_name;
    logic                   r_lenln,  n_lenln,  e_lenln;
    logic                   r_skip,   n_skip,   e_skip;
    logic                   r_ddone,  n_ddone,  e_ddone;
    logic [VALUE_WIDTH-1:0] r_acc,    n_acc,    e_acc;
    logic [1:0]             r_nl,     n_nl,     e_nl;

    logic [ProdW-1:0]       prod;
    logic [ExtW-1:0]        acc_ext;
    logic [3:0]             digit;
    logic                   is_digit;
    logic [1:0]             nl_inc;

    assign digit    = 4'(i_byte - CH_ZERO);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign acc_ext  = ExtW'(e_acc);
    assign nl_inc   = (e_nl < 2'd3) ? e_nl + 2'd1 : e_nl;

    // acc * 10 + digit, saturate when it spills past VALUE_WIDTH bits
    assign prod = (ProdW'(e_acc) << 3) + (ProdW'(e_acc) << 1) + ProdW'(digit);

    always_comb begin
        e_phase = i_new ? PH_METHOD : r_phase;
        e_seg   = i_new ? 4'd0      : r_seg;
        e_get   = i_new ? 1'b1      : r_get;
        e_put   = i_new ? 1'b1      : r_put;
        e_name  = i_new ? 1'b1      : r_name;
        e_lenln = i_new ? 1'b0      : r_lenln;
        e_skip  = i_new ? 1'b0      : r_skip;
        e_ddone = i_new ? 1'b0      : r_ddone;
        e_acc   = i_new ? '0        : r_acc;
        e_nl    = i_new ? 2'd0      : r_nl;
    end

    always_comb begin
        n_phase = e_phase;
        n_seg   = e_seg;
        n_get   = e_get;
        n_put   = e_put;
        n_name  = e_name;
        n_lenln = e_lenln;
        n_skip  = e_skip;
        n_ddone = e_ddone;
        n_acc   = e_acc;
        n_nl    = e_nl;
        o_res   = '0;

        unique case (e_phase)
            PH_METHOD: begin
                if (i_byte == CH_SPACE) begin
                    o_res.valid = 1'b1;
                    if (e_seg == VERB_CHARS && e_get) begin
                        n_phase   = PH_SEARCH;
                        n_nl      = 2'd0;
                        o_res.evt = EV_GET;
                    end else if (e_seg == VERB_CHARS && e_put) begin
                        n_phase   = PH_HEADERS;
                        n_nl      = 2'd0;
                        n_seg     = 4'd0;
                        n_name    = 1'b1;
                        n_acc     = '0;
                        n_ddone   = 1'b0;
                        n_lenln   = 1'b0;
                        n_skip    = 1'b0;
                        o_res.evt = EV_PUT;
                    end else begin
                        n_phase   = PH_INVALID;
                        o_res.evt = EV_BAD;
                    end
                end else begin
                    if (e_seg < VERB_CHARS) begin
                        if (i_byte != get_char(e_seg[1:0])) n_get = 1'b0;
                        if (i_byte != put_char(e_seg[1:0])) n_put = 1'b0;
                    end else begin
                        n_get = 1'b0;
                        n_put = 1'b0;
                    end
                    if (e_seg < SEG_MAX) n_seg = e_seg + 4'd1;
                end
            end
            PH_HEADERS: begin
                if (i_byte == CH_LF) begin
                    n_lenln = 1'b0;
                    n_skip  = 1'b0;
                    n_seg   = 4'd0;
                    n_name  = 1'b1;
                    n_acc   = '0;
                    n_ddone = 1'b0;
                    n_nl    = nl_inc;
                    if (nl_inc >= 2'd2) begin
                        n_phase     = PH_DONE;
                        o_res.valid = 1'b1;
                        o_res.evt   = EV_END;
                    end else if (e_lenln) begin
                        o_res.valid      = 1'b1;
                        o_res.evt        = EV_LEN;
                        o_res.length_val = acc_ext[OUT_WIDTH-1:0];
                    end
                end else if (i_byte != CH_CR) begin
                    n_nl = 2'd0;
                    if (i_byte == CH_COLON) begin
                        if (e_seg == NAME_LEN && e_name) n_lenln = 1'b1;
                        n_seg   = 4'd0;
                        n_name  = 1'b1;
                        n_acc   = '0;
                        n_ddone = 1'b0;
                        n_skip  = 1'b1;
                    end else if (!(e_skip && i_byte == CH_SPACE)) begin
                        n_skip = 1'b0;
                        if (e_seg >= NAME_LEN || i_byte != clen_char(e_seg)) begin
                            n_name = 1'b0;
                        end
                        if (e_seg < SEG_MAX) n_seg = e_seg + 4'd1;
                        if (!e_ddone) begin
                            if (is_digit) begin
                                n_acc = (|prod[ProdW-1:VALUE_WIDTH]) ? '1
                                                                    : prod[VALUE_WIDTH-1:0];
                            end else begin
                                n_ddone = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_SEARCH: begin
                if (i_byte == CH_LF) begin
                    n_nl = nl_inc;
                    if (nl_inc >= 2'd2) begin
                        n_phase     = PH_DONE;
                        o_res.valid = 1'b1;
                        o_res.evt   = EV_END;
                    end
                end else if (i_byte != CH_CR) begin
                    n_nl = 2'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_seg   <= 4'd0;
            r_get   <= 1'b1;
            r_put   <= 1'b1;
            r_name  <= 1'b1;
            r_lenln <= 1'b0;
            r_skip  <= 1'b0;
            r_ddone <= 1'b0;
            r_acc   <= '0;
            r_nl    <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_seg   <= n_seg;
            r_get   <= n_get;
            r_put   <= n_put;
            r_name  <= n_name;
            r_lenln <= n_lenln;
            r_skip  <= n_skip;
            r_ddone <= n_ddone;
            r_acc   <= n_acc;
            r_nl    <= n_nl;
        end
    end

endmodule

>>> hw/rtl/http_request_head_parser.sv
// Path: an accepted byte waits in the input register; the parser step, one pass
// of logic, turns it into its event in the result register behind o_out_valid.
// Throughput: one byte per cycle while the result register is not stalled.
// Reset: synchronous active-low i_rst_n empties both registers and puts the
// parser in the method phase; i_new_request puts it there for its own byte.
// ---------------------------------------------------------------------------
// HTTP request head parser
// Byte-stream parser for the request method and the Content-Length header.
// ---------------------------------------------------------------------------
module http_request_head_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_request,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_length_val
);
    import hrhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;
    logic       r_out_valid;
    t_event     r_out_evt;
    logic [OUT_WIDTH-1:0] r_out_len;

    logic       out_free;
    logic       step;
    logic       accept;
    t_result    res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    hrhp_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_byte (r_in_byte),
        .i_new  (r_in_new),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_new  <= i_new_request;
        end
    end

    // hold the result while downstream stalls the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && step && res.valid) begin
            r_out_evt <= res.evt;
            r_out_len <= res.length_val;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_out_evt;
    assign o_length_val = r_out_len;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP request head parser testbench
// Drives request byte streams through the parser. Directed requests cover
// method decode, header value decode and head end. Random requests are
// mostly well-formed, with random names, values, spacing and line endings,
// plus some noise. An internal parser model predicts every event. Both
// sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

    import hrhp_pkg::*;

    localparam int VALUE_WIDTH  = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [63:0]     VALUE_MAX = {64{1'b1}} >> (64 - VALUE_WIDTH);
    localparam logic [8*3-1:0]  GET_TEXT  = "GET";
    localparam logic [8*3-1:0]  PUT_TEXT  = "PUT";
    localparam logic [8*14-1:0] CLEN_TEXT = "Content-Length";

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_HEADERS,
        PH_SEARCH,
        PH_INVALID,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_event      evt;
        logic [31:0] clen;
    } t_expected_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic [7:0]  i_data_byte;
    logic        i_new_request;
    logic        i_out_stall;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_event_res;
    logic [31:0] o_length_val;

    // Parser model state
    t_phase                 ph;
    logic [3:0]             seg_cnt;
    logic                   get_ok;
    logic                   put_ok;
    logic                   name_ok;
    logic                   len_line;
    logic                   skip_sp;
    logic                   value_end;
    logic [VALUE_WIDTH-1:0] value_acc;
    logic [1:0]             nl_run;

    t_expected_event expected_events[$];
    logic [7:0]      stream_bytes[$];
    int unsigned     sent_items;
    int unsigned     error_count;
    int unsigned     cycle_count;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;

    http_request_head_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_new_request    (i_new_request),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_length_val     (o_length_val)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        ph        = PH_METHOD;
        seg_cnt   = '0;
        get_ok    = 1'b1;
        put_ok    = 1'b1;
        name_ok   = 1'b1;
        len_line  = 1'b0;
        skip_sp   = 1'b0;
        value_end = 1'b0;
        value_acc = '0;
        nl_run    = '0;
    endfunction

    function automatic void start_field();
        seg_cnt   = '0;
        name_ok   = 1'b1;
        value_acc = '0;
        value_end = 1'b0;
    endfunction

    function automatic void bump_count();
        if (seg_cnt < SEG_MAX)
            seg_cnt = seg_cnt + 4'd1;
    endfunction

    function automatic bit parse_header_byte(input logic [7:0] b,
                                             inout t_expected_event ev);
        logic [63:0] digit;
        logic [63:0] acc_wide;
        int          idx;
        bit          hit;
        hit = 1'b0;
        if (b == CH_LF) begin
            if (len_line) begin
                hit     = 1'b1;
                ev.evt  = EV_LEN;
                ev.clen = 32'(value_acc);
            end
            len_line = 1'b0;
            skip_sp  = 1'b0;
            start_field();
            if (nl_run < 2'd3)
                nl_run = nl_run + 2'd1;
            if (nl_run >= 2'd2) begin
                ph      = PH_DONE;
                hit     = 1'b1;
                ev.evt  = EV_END;
                ev.clen = '0;
            end
            return hit;
        end
        if (b == CH_CR)
            return 1'b0;
        nl_run = '0;
        if (b == CH_COLON) begin
            if (seg_cnt == NAME_LEN && name_ok)
                len_line = 1'b1;
            start_field();
            skip_sp = 1'b1;
            return 1'b0;
        end
        if (skip_sp) begin
            if (b == CH_SPACE)
                return 1'b0;
            skip_sp = 1'b0;
        end
        if (seg_cnt < NAME_LEN) begin
            idx = seg_cnt;
            if (b != CLEN_TEXT[8*(13-idx) +: 8])
                name_ok = 1'b0;
        end else begin
            name_ok = 1'b0;
        end
        bump_count();
        if (!value_end) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                digit    = 64'(b - CH_ZERO);
                acc_wide = 64'(value_acc);
                // saturate instead of wrapping
                if (acc_wide > (VALUE_MAX - digit) / 10)
                    value_acc = VALUE_WIDTH'(VALUE_MAX);
                else
                    value_acc = VALUE_WIDTH'(acc_wide * 10 + digit);
            end else begin
                value_end = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic nr,
                                      output t_expected_event ev);
        int idx;
        bit hit;
        hit     = 1'b0;
        ev.evt  = EV_GET;
        ev.clen = '0;
        if (nr)
            clear_parser();
        case (ph)
            PH_METHOD: begin
                if (b == CH_SPACE) begin
                    hit = 1'b1;
                    if (seg_cnt == VERB_CHARS && get_ok) begin
                        ph     = PH_SEARCH;
                        nl_run = '0;
                        ev.evt = EV_GET;
                    end else if (seg_cnt == VERB_CHARS && put_ok) begin
                        ph       = PH_HEADERS;
                        nl_run   = '0;
                        start_field();
                        len_line = 1'b0;
                        skip_sp  = 1'b0;
                        ev.evt   = EV_PUT;
                    end else begin
                        ph     = PH_INVALID;
                        ev.evt = EV_BAD;
                    end
                end else begin
                    if (seg_cnt < VERB_CHARS) begin
                        idx = seg_cnt;
                        if (b != GET_TEXT[8*(2-idx) +: 8])
                            get_ok = 1'b0;
                        if (b != PUT_TEXT[8*(2-idx) +: 8])
                            put_ok = 1'b0;
                    end else begin
                        get_ok = 1'b0;
                        put_ok = 1'b0;
                    end
                    bump_count();
                end
            end
            PH_HEADERS: hit = parse_header_byte(b, ev);
            PH_SEARCH: begin
                if (b == CH_LF) begin
                    if (nl_run < 2'd3)
                        nl_run = nl_run + 2'd1;
                    if (nl_run >= 2'd2) begin
                        ph     = PH_DONE;
                        hit    = 1'b1;
                        ev.evt = EV_END;
                    end
                end else if (b != CH_CR) begin
                    nl_run = '0;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_expected_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                $error("event with nothing expected: event_res=%0d length_val=%0d",
                       o_event_res, o_length_val);
                error_count++;
            end else begin
                want = expected_events.pop_front();
                if (o_event_res !== want.evt) begin
                    $error("event_res mismatch: expected %0d, got %0d",
                           want.evt, o_event_res);
                    error_count++;
                end
                if (o_length_val !== want.clen) begin
                    $error("length_val mismatch: expected %0d, got %0d",
                           want.clen, o_length_val);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic nr);
        t_expected_event ev;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_new_request <= nr;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sent_items++;
        if (parse_byte(b, nr, ev))
            expected_events.push_back(ev);
    endtask

    task automatic send_text(input string s, input bit fresh);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], (i == 0) ? fresh : 1'b0);
    endtask

    // Hold off input until every pending event has come out
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream_bytes.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++)
            stream_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void add_header_line();
        string name;
        int    pick;
        name = "Content-Length";
        pick = $urandom_range(99);
        if (pick < 55) begin
            add_text(name);
        end else if (pick < 70) begin
            // near miss on the header name
            case ($urandom_range(2))
                0:       name[$urandom_range(13)] = byte'($urandom_range(33, 126));
                1:       name = name.substr(0, 12);
                default: name = {name, "s"};
            endcase
            add_text(name);
        end else begin
            repeat ($urandom_range(6))
                stream_bytes.push_back(8'($urandom_range(33, 126)));
        end
        add_text(":");
        if ($urandom_range(9) == 0) begin
            add_digits($urandom_range(1, 3));
            add_text(":");
        end
        repeat ($urandom_range(3)) add_text(" ");
        if ($urandom_range(9) == 0)
            add_text($urandom_range(1) ? "-" : "+");
        pick = $urandom_range(99);
        if (pick < 5)
            add_text($urandom_range(1) ? "4294967295" : "4294967296");
        else if (pick < 15)
            add_digits(0);
        else if (pick < 70)
            add_digits($urandom_range(1, 5));
        else if (pick < 85)
            add_digits($urandom_range(6, 9));
        else
            add_digits($urandom_range(10, 12));
        if ($urandom_range(99) < 15)
            add_text(" ;q=1");
        add_text(($urandom_range(99) < 70) ? "\r\n" : "\n");
    endfunction

    task automatic send_random_request();
        int    pick;
        bit    fresh;
        string letters;
        letters = "GETPUX";
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            return;
        end
        stream_bytes.delete();
        fresh = ($urandom_range(99) < 92);
        pick  = $urandom_range(99);
        if (pick < 45) begin
            add_text("PUT ");
            repeat ($urandom_range(4)) add_header_line();
        end else if (pick < 75) begin
            add_text("GET ");
            repeat ($urandom_range(3)) begin
                repeat ($urandom_range(1, 10))
                    stream_bytes.push_back(8'($urandom_range(32, 126)));
                add_text($urandom_range(1) ? "\r\n" : "\n");
            end
        end else begin
            repeat ($urandom_range(5))
                stream_bytes.push_back(letters[$urandom_range(5)]);
            add_text(" ");
        end
        if ($urandom_range(99) < 90)
            add_text($urandom_range(1) ? "\r\n" : "\n");
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 4))
                stream_bytes.push_back(8'($urandom_range(255)));
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i], (i == 0) ? fresh : 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_method_decode();
        send_text("GET \r\n\r\n", 1'b1);
        send_text(" ", 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_text(" x", 1'b0);
        send_text("PUTS ", 1'b1);
        // restart in the middle of a method
        send_text("GET", 1'b1);
        send_text("PUT \n\n", 1'b1);
    endtask

    task automatic test_content_length();
        send_text("PUT Content-Length:  4294967296\r\n", 1'b1);
        send_text("Content-Length:-7\n", 1'b0);
        send_text("Content-Length:5:12 \n", 1'b0);
        send_text("content-length:3\n", 1'b0);
        // a lone colon keeps the line from being blank
        send_text(":\n\r\n", 1'b0);
        send_text("Z", 1'b0);
    endtask

    task automatic test_random_requests(input int unsigned count);
        int unsigned start;
        start = sent_items;
        while (sent_items - start < count) begin
            send_random_request();
            if ($urandom_range(99) < 2)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_data_byte   <= '0;
        i_new_request <= 1'b0;
        error_count   = 0;
        sent_items    = 0;
        send_idle_pct = 12;
        recv_idle_pct = 72;
        clear_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_method_decode();
        test_content_length();
        wait_for_drain();

        test_random_requests(550);
        send_idle_pct = 72;
        recv_idle_pct = 12;
        test_random_requests(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_requests(500);

        wait_for_drain();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
